[rtl/core/kpa_pkg.sv]
package kpa_pkg;

  typedef struct packed {
    logic [63:0] function_address;
    logic [31:0] call_count;
    logic [15:0] reentrance_peak;
    logic [47:0] inclusive_ticks;
    logic [47:0] exclusive_ticks;
    logic        batch_last;
  } kpa_in_t;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic        inserted;
    logic        dropped;
    logic [63:0] total_calls;
    logic [15:0] total_reentrance;
    logic [63:0] total_inclusive;
    logic [63:0] total_exclusive;
    logic        batch_new;
  } kpa_out_t;

  // Back end sequencing
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FETCH, S_RMW, S_OUT} kpa_back_st_t;

  localparam int unsigned IdxOutW = 6;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

[rtl/core/kpa_in_if.sv]
interface kpa_in_if import kpa_pkg::*; ();
  logic    valid;
  logic    ready;
  kpa_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/kpa_out_if.sv]
interface kpa_out_if import kpa_pkg::*; ();
  logic     valid;
  logic     ready;
  kpa_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/kpa_front.sv]
// Front: hold items in a two-entry queue toward the back end.
module kpa_front import kpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  kpa_in_if.sink  in_ch,
  output logic    q_valid,
  output kpa_in_t q_data,
  input  logic    q_pop
);
  kpa_in_t mem_r [2];
  logic    wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_ch.valid && in_ch.ready) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) mem_r[wp_r] <= in_ch.data;
  end
endmodule

[rtl/core/kpa_back.sv]
// Back: scan the key table for a hit or free slot, then update that slot (none if the table is full).
module kpa_back import kpa_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  kpa_in_t q_data,
  output logic    q_pop,
  kpa_out_if.source out_ch
);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  kpa_back_st_t st_r, st_nxt;

  logic [ENTRIES-1:0] valid_r;
  logic [63:0] key_mem [ENTRIES];
  logic [63:0] calls_mem [ENTRIES];
  logic [15:0] depth_mem [ENTRIES];
  logic [63:0] incl_mem [ENTRIES];
  logic [63:0] excl_mem [ENTRIES];

  kpa_in_t     it_r;
  logic [IW:0] ptr_r;
  logic        hit_r, free_r;
  logic [IW-1:0] hslot_r, fslot_r;
  logic [IW-1:0] wslot_r;
  logic        bins_r;
  logic [63:0] kq_r, cq_r, iq_r, eq_r;
  logic [15:0] dq_r;
  kpa_out_t    res_r;
  logic [IW-1:0] pidx;

  assign pidx  = ptr_r[IW-1:0];
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = res_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = S_SCAN;
      S_SCAN:  if (ptr_r == (IW+1)'(ENTRIES)) st_nxt = S_FETCH;
      S_FETCH: st_nxt = S_RMW;
      S_RMW:   st_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // Scan one slot a cycle; reads registered, compared next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; bins_r <= 1'b0; ptr_r <= '0; hit_r <= 1'b0; free_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_data; ptr_r <= '0; hit_r <= 1'b0; free_r <= 1'b0;
        end
        S_SCAN: begin
          if (ptr_r != (IW+1)'(ENTRIES)) ptr_r <= ptr_r + 1'b1;
          if (ptr_r != '0 && !hit_r) begin
            if (valid_r[IW'(ptr_r - 1'b1)]) begin
              if (kq_r == it_r.function_address) begin
                hit_r <= 1'b1; hslot_r <= IW'(ptr_r - 1'b1);
              end
            end else if (!free_r) begin
              free_r <= 1'b1; fslot_r <= IW'(ptr_r - 1'b1);
            end
          end
        end
        S_FETCH: ;
        S_RMW: begin
          wslot_r <= hit_r ? hslot_r : fslot_r;
          res_r.batch_new <= 1'b0;
          res_r.inserted  <= !hit_r && free_r;
          res_r.dropped   <= !hit_r && !free_r;
          if (hit_r) begin
            res_r.entry_index      <= IdxOutW'(hslot_r);
            res_r.total_calls      <= sat_add64(cq_r, {32'd0, it_r.call_count});
            res_r.total_reentrance <= (it_r.reentrance_peak > dq_r) ?
                                      it_r.reentrance_peak : dq_r;
            res_r.total_inclusive  <= sat_add64(iq_r, {16'd0, it_r.inclusive_ticks});
            res_r.total_exclusive  <= sat_add64(eq_r, {16'd0, it_r.exclusive_ticks});
          end else if (free_r) begin
            valid_r[fslot_r] <= 1'b1;
            res_r.entry_index      <= IdxOutW'(fslot_r);
            res_r.total_calls      <= {32'd0, it_r.call_count};
            res_r.total_reentrance <= it_r.reentrance_peak;
            res_r.total_inclusive  <= {16'd0, it_r.inclusive_ticks};
            res_r.total_exclusive  <= {16'd0, it_r.exclusive_ticks};
          end else begin
            res_r.entry_index <= '0; res_r.total_calls <= '0;
            res_r.total_reentrance <= '0; res_r.total_inclusive <= '0;
            res_r.total_exclusive <= '0;
          end
          if (it_r.batch_last) begin
            res_r.batch_new <= bins_r || (!hit_r && free_r);
            bins_r <= 1'b0;
          end else if (!hit_r && free_r) begin
            bins_r <= 1'b1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // Key memory: read during scan, written on insert
  always_ff @(posedge clk) begin
    if (st_r == S_SCAN && ptr_r != (IW+1)'(ENTRIES)) kq_r <= key_mem[pidx];
    if (st_r == S_RMW && !hit_r && free_r) key_mem[fslot_r] <= it_r.function_address;
  end

  // Accumulator memories: read hit slot in fetch, written in the output state unless dropped
  always_ff @(posedge clk) begin
    cq_r <= calls_mem[hslot_r];
    dq_r <= depth_mem[hslot_r];
    iq_r <= incl_mem[hslot_r];
    eq_r <= excl_mem[hslot_r];
    if (st_r == S_OUT && !res_r.dropped) begin
      calls_mem[wslot_r] <= res_r.total_calls;
      depth_mem[wslot_r] <= res_r.total_reentrance;
      incl_mem[wslot_r]  <= res_r.total_inclusive;
      excl_mem[wslot_r]  <= res_r.total_exclusive;
    end
  end
endmodule

[rtl/core/keyed_profile_accumulator.sv]
// Channel | Direction | Payload
// in_     | sink      | address, calls, peak, inclusive/exclusive ticks, batch_last
// out_    | source    | entry index, inserted/dropped, totals, batch_new
// For each item the back end scans one key slot per cycle
// through the single key memory read port, fetches the hit slot's totals,
// then updates and presents the result.
// Reset (rst_n low, synchronous) clears the slot valid bits and the batch flag.
// A two-entry queue takes items while the back end works or the result stalls.
module keyed_profile_accumulator import kpa_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_function_address,
  input  logic [31:0] in_call_count,
  input  logic [15:0] in_reentrance_peak,
  input  logic [47:0] in_inclusive_ticks,
  input  logic [47:0] in_exclusive_ticks,
  input  logic        in_batch_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_entry_index,
  output logic        out_inserted,
  output logic        out_dropped,
  output logic [63:0] out_total_calls,
  output logic [15:0] out_total_reentrance,
  output logic [63:0] out_total_inclusive,
  output logic [63:0] out_total_exclusive,
  output logic        out_batch_new
);
  kpa_in_if  in_ch ();
  kpa_out_if out_ch ();
  logic    q_valid, q_pop;
  kpa_in_t q_data;

  assign in_ch.valid = in_valid;
  assign in_ready    = in_ch.ready;
  assign in_ch.data  = '{in_function_address, in_call_count, in_reentrance_peak,
                         in_inclusive_ticks, in_exclusive_ticks, in_batch_last};
  assign out_valid    = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_entry_index      = out_ch.data.entry_index;
  assign out_inserted         = out_ch.data.inserted;
  assign out_dropped          = out_ch.data.dropped;
  assign out_total_calls      = out_ch.data.total_calls;
  assign out_total_reentrance = out_ch.data.total_reentrance;
  assign out_total_inclusive  = out_ch.data.total_inclusive;
  assign out_total_exclusive  = out_ch.data.total_exclusive;
  assign out_batch_new        = out_ch.data.batch_new;

  kpa_front u_front (.clk, .rst_n, .in_ch(in_ch.sink), .q_valid, .q_data, .q_pop);
  kpa_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop, .out_ch(out_ch.source));
endmodule
